// File: src/tlfs_pkg.sv
// ----------------------------------------------------------------------------
// tlfs_pkg
// shared types and constants of the three-level feedback scheduler
// ----------------------------------------------------------------------------
package tlfs_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_PICK    = 2'd1,
    FUNC_AGE     = 2'd2,
    FUNC_CHECK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_STEP      = 2'd1;
  localparam logic [1:0] REG_QUANTUM   = 2'd2;

  localparam logic [7:0] PRIO_MAX = 8'd149;
  localparam logic [7:0] PRIO_L1  = 8'd100;
  localparam logic [7:0] PRIO_L2  = 8'd50;
  localparam logic [7:0] BOUND_L2 = 8'd99;
  localparam logic [7:0] BOUND_L3 = 8'd49;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] remain_estimate;
    logic [31:0] now_ticks;
    logic [1:0]  running_level;
    logic [15:0] running_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] picked_id;
    logic [1:0] picked_level;
    logic       preempt;
  } out_item_t;

  // one slot entry as held in the table memory
  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  priority_v;
    logic [15:0] remain;
    logic [1:0]  level;
    logic [15:0] waited;
    logic [31:0] wait_start;
    logic [15:0] order;
  } entry_t;

  // strict ranking of a ahead of b within a level
  function automatic logic ranks_ahead(input entry_t a, input entry_t b,
                                       input logic [15:0] ctr);
    logic [15:0] age_a;
    logic [15:0] age_b;
    age_a = ctr - a.order - 16'd1;
    age_b = ctr - b.order - 16'd1;
    if (a.level == 2'd1 && a.remain != b.remain) return a.remain < b.remain;
    if (a.level == 2'd2 && a.priority_v != b.priority_v)
      return a.priority_v > b.priority_v;
    return age_a > age_b;
  endfunction

endpackage

// File: src/tlfs_table.sv
// ----------------------------------------------------------------------------
// tlfs_table
// slot table memory, one entry per slot, registered read
// ----------------------------------------------------------------------------
module tlfs_table #(
  parameter int SLOTS = 32,
  parameter int IW    = 5
) (
  input  logic              clk,
  input  logic [IW-1:0]     rd_addr,
  output tlfs_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  tlfs_pkg::entry_t  wr_data
);
  import tlfs_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/three_level_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler
// three-level ready-queue scheduler over a slot table memory
// ----------------------------------------------------------------------------
// channel  direction  payload     handshake
// in       input      in_item_t   in_valid / in_ready
// out      output     out_item_t  out_valid / out_ready
// cfg      input      idx, data   cfg_we (no wait)
//
// one item at a time; a new input transfer waits until the last result is taken
// enqueue needs only the valid bits: the input transfer leads to S_SCAN, which writes the slot and registers the result
// pick and check sweep the table once, one memory read a cycle
// aging tick: one aging sweep, then one promotion sweep per promoted task plus one per level
// the slot valid bits live in flip-flops and reset clears them at once
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler #(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlfs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlfs_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [15:0]          cfg_data
);
  import tlfs_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_AGE, S_PROMO, S_APPLY, S_DONE
  } state_t;

  // configuration registers
  logic [15:0] aging_threshold;
  logic [7:0]  aging_step;
  logic [15:0] fifo_quantum;

  always_ff @(posedge clk) begin
    if (rst) begin
      aging_threshold <= 16'd1500;
      aging_step      <= 8'd10;
      fifo_quantum    <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD: aging_threshold <= cfg_data;
        REG_STEP:      aging_step      <= cfg_data[7:0];
        REG_QUANTUM:   fifo_quantum    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t      state;
  in_item_t    item;
  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] mark2;  // level 2 slots due for promotion this tick
  logic [SLOTS-1:0] mark3;  // level 3 slots due for promotion this tick
  logic [15:0] order_counter;
  logic [CW-1:0] cnt;       // issue index of the sweep
  logic        rd_live;     // read data of the previous cycle belongs to sweep
  logic [IW-1:0] rd_idx;    // slot of the data now on rd_data
  logic [1:0]  promo_from;

  // per level best slot, found while sweeping
  logic [2:0]  found;
  logic [IW-1:0] best_idx [3];
  entry_t      best_e [3];

  entry_t      rd_data;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t      wr_data;
  logic [IW-1:0] rd_addr;

  assign rd_addr = cnt[IW-1:0];

  tlfs_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  // aging update of the entry being read
  logic [31:0] elapsed;
  logic [16:0] w_sum;
  logic [15:0] w_sat;
  logic [8:0]  p_sum;
  entry_t      aged;
  always_comb begin
    elapsed = item.now_ticks - rd_data.wait_start;
    w_sum   = {1'b0, rd_data.waited} + {1'b0, elapsed[15:0]};
    // wait total saturates before the threshold test
    w_sat   = (elapsed > 32'h0000_FFFF || w_sum[16]) ? 16'hFFFF : w_sum[15:0];
    aged = rd_data;
    aged.wait_start = item.now_ticks;
    p_sum = {1'b0, rd_data.priority_v} + {1'b0, aging_step};
    if (w_sat >= aging_threshold) begin
      aged.waited = w_sat - aging_threshold;
      aged.priority_v = (p_sum > {1'b0, PRIO_MAX}) ? PRIO_MAX : p_sum[7:0];
    end else begin
      aged.waited = w_sat;
    end
  end

  // level used for ranking in the current sweep
  logic [1:0] cur_lvl;
  logic       consider;
  logic [1:0] li;
  logic       promo_mark;
  always_comb begin
    cur_lvl    = rd_data.level;
    li         = cur_lvl - 2'd1;
    promo_mark = (promo_from == 2'd2) ? mark2[rd_idx] : mark3[rd_idx];
    consider   = rd_live && valid_q[rd_idx] && cur_lvl != 2'd0;
    if (state == S_PROMO) consider = consider && promo_mark && cur_lvl == promo_from;
  end

  logic sweep_end;
  assign sweep_end = rd_live && (rd_idx == IW'(SLOTS - 1));

  // enqueue needs only the valid bits
  logic [IW-1:0] first_free;
  logic          any_free;
  always_comb begin
    first_free = '0;
    any_free   = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        first_free = IW'(i);
        any_free   = 1'b1;
      end
    end
  end

  // enqueue is done within the S_SCAN state, memory write included
  logic enq_cycle;
  logic enq_wr;
  assign enq_cycle = state == S_SCAN && item.func == FUNC_ENQUEUE;
  assign enq_wr    = enq_cycle && item.task_priority <= PRIO_MAX && any_free;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = aged;
    if (state == S_AGE && rd_live && valid_q[rd_idx]) wr_en = 1'b1;
    if (state == S_APPLY) begin
      wr_en   = found[promo_from - 2'd1];
      wr_addr = best_idx[promo_from - 2'd1];
      wr_data = best_e[promo_from - 2'd1];
      wr_data.level = promo_from - 2'd1;
      wr_data.order = order_counter;
    end
    if (enq_cycle) begin
      wr_en   = enq_wr;
      wr_addr = first_free;
      wr_data.task_id    = item.task_id;
      wr_data.priority_v = item.task_priority;
      wr_data.remain     = item.remain_estimate;
      wr_data.level      = (item.task_priority >= PRIO_L1) ? 2'd1 :
                           (item.task_priority >= PRIO_L2) ? 2'd2 : 2'd3;
      wr_data.waited     = 16'd0;
      wr_data.wait_start = item.now_ticks;
      wr_data.order      = order_counter;
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic [1:0] pick_lvl;
  always_comb begin
    pick_lvl = found[0] ? 2'd1 : found[1] ? 2'd2 : 2'd3;
  end

  logic preempt_calc;
  always_comb begin
    unique case (item.running_level)
      2'd1: preempt_calc = found[0] && item.remain_estimate > best_e[0].remain;
      2'd2: preempt_calc = found[0];
      default: preempt_calc = found[0] || found[1] ||
                              (found[2] && item.running_ticks >= fifo_quantum);
    endcase
  end

  // result of the item that ends in this cycle
  out_item_t res_next;
  logic      finish;
  always_comb begin
    res_next = '0;
    if (enq_cycle) begin
      if (item.task_priority > PRIO_MAX) res_next.status = ST_BAD_PRIO;
      else if (!any_free) res_next.status = ST_FULL;
    end else if (state == S_DONE && item.func == FUNC_PICK) begin
      if (found == 3'b000) res_next.status = ST_NONE;
      else begin
        res_next.picked_id    = best_e[pick_lvl - 2'd1].task_id;
        res_next.picked_level = pick_lvl;
      end
    end else if (state == S_DONE && item.func == FUNC_CHECK) begin
      res_next.preempt = preempt_calc;
    end
    finish = enq_cycle || (state == S_DONE && item.func != FUNC_AGE) ||
             (state == S_APPLY && !found[promo_from - 2'd1] && promo_from == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid_q       <= '0;
      order_counter <= '0;
      out_valid     <= 1'b0;
      rd_live       <= 1'b0;
      cnt           <= '0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
        out_data  <= res_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item    <= in_data;
            cnt     <= '0;
            rd_live <= 1'b0;
            found   <= '0;
            state   <= (in_data.func == FUNC_AGE) ? S_AGE : S_SCAN;
          end
        end
        S_SCAN, S_AGE, S_PROMO: begin
          if (enq_cycle) begin
            if (enq_wr) begin
              valid_q[first_free] <= 1'b1;
              order_counter       <= order_counter + 16'd1;
            end
            state <= S_IDLE;
          end else begin
            if ({1'b0, cnt} < (CW+1)'(SLOTS)) begin
              cnt <= cnt + CW'(1);
              rd_live <= 1'b1;
              rd_idx  <= cnt[IW-1:0];
            end else begin
              rd_live <= 1'b0;
            end
            // promotion candidates from the aged priorities
            if (state == S_AGE && rd_live) begin
              mark2[rd_idx] <= valid_q[rd_idx] && aged.level == 2'd2 &&
                               aged.priority_v > BOUND_L2;
              mark3[rd_idx] <= valid_q[rd_idx] && aged.level == 2'd3 &&
                               aged.priority_v > BOUND_L3;
            end
            if (consider && (!found[li] || ranks_ahead(rd_data, best_e[li],
                                                       order_counter))) begin
              found[li]    <= 1'b1;
              best_idx[li] <= rd_idx;
              best_e[li]   <= rd_data;
            end
            if (sweep_end) begin
              unique case (state)
                S_AGE: begin
                  promo_from <= 2'd2;
                  state      <= S_DONE;
                end
                S_PROMO: state <= S_APPLY;
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_APPLY: begin
          if (found[promo_from - 2'd1]) begin
            if (promo_from == 2'd2) mark2[best_idx[1]] <= 1'b0;
            else mark3[best_idx[2]] <= 1'b0;
            order_counter <= order_counter + 16'd1;
            cnt <= '0; rd_live <= 1'b0; found <= '0;
            state <= S_PROMO;
          end else if (promo_from == 2'd2) begin
            promo_from <= 2'd3;
            state      <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (item.func == FUNC_AGE) begin
            // promotion pass from promo_from
            cnt <= '0; rd_live <= 1'b0; found <= '0;
            state <= S_PROMO;
          end else begin
            if (item.func == FUNC_PICK && found != 3'b000)
              valid_q[best_idx[pick_lvl - 2'd1]] <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("input taken while busy");
  a_enq_slot_free: assert property (@(posedge clk) disable iff (rst)
    enq_wr |-> !valid_q[first_free])
    else $error("enqueue into occupied slot");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the three-level feedback scheduler: directed and
// random enqueue, pick, aging and preempt-check items are driven over the
// valid/ready input, each transfer is fed through a behavioral scheduler
// model, and every output transfer is compared field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import tlfs_pkg::*;

  localparam int NSLOT = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  three_level_feedback_scheduler #(.SLOTS(NSLOT)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // scheduler model state
  logic [15:0] m_thresh, m_quantum;
  logic [7:0]  m_step;
  logic        s_valid [NSLOT];
  logic [7:0]  s_task [NSLOT];
  logic [7:0]  s_prio [NSLOT];
  logic [15:0] s_remain [NSLOT];
  logic [1:0]  s_level [NSLOT];
  logic [15:0] s_waited [NSLOT];
  logic [31:0] s_start [NSLOT];
  logic [15:0] s_order [NSLOT];
  logic        s_mark [NSLOT];
  logic [15:0] arrival_ctr;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int errors = 0;
  int mismatches = 0;
  bit stim_done = 0;
  int hold_cycles = 0;

  function automatic bit slot_ahead(int i, int j, int lvl);
    logic [15:0] ai, aj;
    ai = arrival_ctr - s_order[i] - 16'd1;
    aj = arrival_ctr - s_order[j] - 16'd1;
    if (lvl == 1 && s_remain[i] != s_remain[j]) return s_remain[i] < s_remain[j];
    if (lvl == 2 && s_prio[i] != s_prio[j]) return s_prio[i] > s_prio[j];
    return ai > aj;
  endfunction

  function automatic int front_of(int lvl, bit marked_only);
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!s_valid[i] || s_level[i] != lvl) continue;
      if (marked_only && !s_mark[i]) continue;
      if (b < 0 || slot_ahead(i, b, lvl)) b = i;
    end
    return b;
  endfunction

  task automatic stamp_arrival(int i);
    s_order[i] = arrival_ctr;
    arrival_ctr = arrival_ctr + 16'd1;
  endtask

  task automatic promote_level(int from, int bound);
    int b;
    for (int i = 0; i < NSLOT; i++)
      s_mark[i] = s_valid[i] && s_level[i] == from && s_prio[i] > bound;
    forever begin
      b = front_of(from, 1);
      if (b < 0) break;
      s_mark[b] = 0;
      s_level[b] = 2'(from - 1);
      stamp_arrival(b);
    end
  endtask

  task automatic model_reset();
    m_thresh = 16'd1500; m_step = 8'd10; m_quantum = 16'd100;
    arrival_ctr = '0;
    for (int i = 0; i < NSLOT; i++) begin
      s_valid[i] = 0; s_mark[i] = 0;
    end
  endtask

  // compute the scheduler's answer to one accepted item
  task automatic schedule_item(in_item_t it);
    out_item_t r;
    int f, b, lvl, b1;
    logic [32:0] w;
    logic [8:0] p;
    r = '0;
    case (func_t'(it.func))
      FUNC_ENQUEUE: begin
        f = -1;
        for (int i = 0; i < NSLOT; i++) if (f < 0 && !s_valid[i]) f = i;
        if (it.task_priority > PRIO_MAX) r.status = ST_BAD_PRIO;
        else if (f < 0) r.status = ST_FULL;
        else begin
          s_valid[f] = 1; s_task[f] = it.task_id; s_prio[f] = it.task_priority;
          s_remain[f] = it.remain_estimate;
          s_level[f] = it.task_priority >= PRIO_L1 ? 2'd1 :
                       (it.task_priority >= PRIO_L2 ? 2'd2 : 2'd3);
          s_waited[f] = '0; s_start[f] = it.now_ticks;
          stamp_arrival(f);
        end
      end
      FUNC_PICK: begin
        b = -1; lvl = 0;
        for (int l = 1; l <= 3; l++)
          if (b < 0) begin
            b = front_of(l, 0);
            lvl = l;
          end
        if (b < 0) r.status = ST_NONE;
        else begin
          s_valid[b] = 0; r.picked_id = s_task[b]; r.picked_level = 2'(lvl);
        end
      end
      FUNC_AGE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!s_valid[i]) continue;
          w = {17'd0, s_waited[i]} + {1'b0, it.now_ticks - s_start[i]};
          if (w > 33'hFFFF) w = 33'hFFFF;
          if (w >= m_thresh) begin
            p = {1'b0, s_prio[i]} + {1'b0, m_step};
            w = w - m_thresh;
            s_prio[i] = p > 9'd149 ? PRIO_MAX : p[7:0];
          end
          s_waited[i] = w[15:0];
          s_start[i] = it.now_ticks;
        end
        promote_level(2, BOUND_L2);
        promote_level(3, BOUND_L3);
      end
      default: begin
        b1 = front_of(1, 0);
        if (it.running_level == 2'd1) begin
          if (b1 >= 0 && it.remain_estimate > s_remain[b1]) r.preempt = 1;
        end else if (it.running_level == 2'd2) begin
          if (b1 >= 0) r.preempt = 1;
        end else begin
          if (b1 >= 0 || front_of(2, 0) >= 0) r.preempt = 1;
          else if (front_of(3, 0) >= 0 && it.running_ticks >= m_quantum) r.preempt = 1;
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  // driver: random gap per item, valid held until the transfer
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      schedule_item(in_data);
      send_gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) send_gap = 0;
      if (send_gap == 0 && pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap--;
      else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor: random stall per result, one long hold-off when asked
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.status !== out_data.status || e.picked_id !== out_data.picked_id ||
              e.picked_level !== out_data.picked_level || e.preempt !== out_data.preempt) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
        recv_gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0 && !(out_valid && out_ready && recv_gap == 0)) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(func_t f, logic [7:0] pr, logic [31:0] now);
    in_item_t it;
    it.func = f;
    it.task_id = 8'($urandom);
    it.task_priority = pr;
    it.remain_estimate = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 40));
    it.now_ticks = now;
    it.running_level = 2'($urandom_range(0, 3));
    it.running_ticks = ($urandom_range(0, 1)) ? 16'($urandom) :
                       16'($urandom_range(0, 200));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    case (idx)
      REG_THRESHOLD: m_thresh = val;
      REG_STEP:      m_step = val[7:0];
      default:       m_quantum = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [31:0] clock_now;

  // random item with mostly valid priorities and a drifting tick count
  task automatic queue_random();
    int k;
    logic [7:0] pr;
    k = $urandom_range(0, 9);
    clock_now = clock_now + ($urandom_range(0, 7) == 0 ? $urandom :
                             $urandom_range(0, 3000));
    if ($urandom_range(0, 15) == 0) pr = 8'($urandom);
    else pr = 8'($urandom_range(0, 149));
    if (k < 4) pending_items.push_back(make_item(FUNC_ENQUEUE, pr, clock_now));
    else if (k < 6) pending_items.push_back(make_item(FUNC_PICK, pr, clock_now));
    else if (k < 8) pending_items.push_back(make_item(FUNC_AGE, pr, clock_now));
    else pending_items.push_back(make_item(FUNC_CHECK, pr, clock_now));
  endtask

  initial begin
    in_item_t it;
    model_reset();
    clock_now = 32'd1000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pick, bad priority, level bounds, checks, aging
    pending_items.push_back(make_item(FUNC_PICK, 8'd0, 32'd0));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd150, 32'd0));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd255, 32'd0));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd0, 32'd0));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd49, 32'd10));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd50, 32'd20));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd99, 32'd30));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd100, 32'd40));
    pending_items.push_back(make_item(FUNC_ENQUEUE, 8'd149, 32'd50));
    it = make_item(FUNC_CHECK, 8'd0, 32'd60); it.running_level = 2'd1;
    it.remain_estimate = 16'hFFFF; pending_items.push_back(it);
    it.running_level = 2'd0; pending_items.push_back(it);
    it.running_level = 2'd2; pending_items.push_back(it);
    pending_items.push_back(make_item(FUNC_AGE, 8'd0, 32'd5000));
    pending_items.push_back(make_item(FUNC_AGE, 8'd0, 32'hFFFF_FFFF));
    for (int i = 0; i < 8; i++) pending_items.push_back(make_item(FUNC_PICK, 8'd0, 32'd0));
    it = make_item(FUNC_CHECK, 8'd0, 32'd0); it.running_level = 2'd3;
    it.running_ticks = 16'hFFFF; pending_items.push_back(it);
    wait_idle();

    // fill the table past full while the receiver holds off
    write_reg(REG_THRESHOLD, 16'd1);
    write_reg(REG_STEP, 16'd149);
    write_reg(REG_QUANTUM, 16'd1);
    hold_cycles = 3000;
    for (int i = 0; i < 36; i++)
      pending_items.push_back(make_item(FUNC_ENQUEUE, 8'($urandom_range(0, 149)),
                                        32'($urandom_range(0, 5000))));
    pending_items.push_back(make_item(FUNC_AGE, 8'd0, 32'd6000));
    for (int i = 0; i < 34; i++) pending_items.push_back(make_item(FUNC_PICK, 8'd0, 32'd0));
    wait_idle();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_THRESHOLD, 16'hFFFF); write_reg(REG_STEP, 16'd0);
                 write_reg(REG_QUANTUM, 16'hFFFF); end
        1: begin write_reg(REG_THRESHOLD, 16'd1500); write_reg(REG_STEP, 16'd10);
                 write_reg(REG_QUANTUM, 16'd100); end
        default: begin write_reg(REG_THRESHOLD, 16'($urandom_range(1, 4000)));
                 write_reg(REG_STEP, 16'($urandom_range(0, 149)));
                 write_reg(REG_QUANTUM, 16'($urandom_range(1, 300))); end
      endcase
      for (int i = 0; i < 150; i++) queue_random();
      wait_idle();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
